FILE: design/smx_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the exponential factor table for the softmax block
// no dependencies

package smx_pkg;

  // default vector capacity
  localparam int MAX_LEN_DEF = 64;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int PROB_W   = 16;
  localparam int POS_W    = 6;
  localparam int SUM_W    = 22;
  localparam int TDATA_OUT_W = 24;

  // exponential unit: one bit of the distance per step
  localparam int EXP_BITS   = 12;
  localparam int EXP_STEP_W = 4;
  localparam int ACC_W      = 32;

  // divider: quotient is below 2^17
  localparam int DIV_STEPS  = 17;
  localparam int DIV_STEP_W = 5;
  localparam int NUM_W      = 33;

  // status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  // round(exp(-2^k / 256) * 2^32)
  function automatic logic [ACC_W-1:0] expk(input logic [EXP_STEP_W-1:0] k);
    logic [ACC_W-1:0] v;
    case (k)
      4'd0:    v = 32'd4278222805;
      4'd1:    v = 32'd4261543595;
      4'd2:    v = 32'd4228380001;
      4'd3:    v = 32'd4162825044;
      4'd4:    v = 32'd4034748382;
      4'd5:    v = 32'd3790295335;
      4'd6:    v = 32'd3344923893;
      4'd7:    v = 32'd2605029347;
      4'd8:    v = 32'd1580030169;
      4'd9:    v = 32'd581260615;
      4'd10:   v = 32'd78665070;
      4'd11:   v = 32'd1440801;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/smx_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module smx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/smx_exp.sv
`timescale 1ns / 1ps
// iterative exponential exp(-n/256) in q0.16, one distance bit per cycle
// depends on smx_pkg

module smx_exp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [smx_pkg::SAMPLE_W-1:0]    delta,
  output logic [smx_pkg::PROB_W-1:0]      e,
  output smx_pkg::unit_status_t           status
);

  logic                               busy;
  logic                               done;
  logic [smx_pkg::EXP_STEP_W-1:0]     step;
  logic [smx_pkg::ACC_W-1:0]          acc;
  logic                               unity;
  logic                               zero;
  logic [smx_pkg::EXP_BITS-1:0]       nbits;
  logic [smx_pkg::ACC_W-1:0]          factor;
  logic [2*smx_pkg::ACC_W-1:0]        prod;
  logic [2*smx_pkg::ACC_W-1:0]        prod_rnd;
  logic [smx_pkg::ACC_W-1:0]          acc_next;
  logic [smx_pkg::ACC_W:0]            e_rnd;
  logic                               far;

  // one multiply and round per step
  assign far      = (delta[smx_pkg::SAMPLE_W-1:smx_pkg::EXP_BITS] != '0);
  assign factor   = smx_pkg::expk(step);
  assign prod     = acc * factor;
  assign prod_rnd = prod + (64'd1 << 31);
  assign acc_next = prod_rnd[2*smx_pkg::ACC_W-1:smx_pkg::ACC_W];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        if (far) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == smx_pkg::EXP_STEP_W'(smx_pkg::EXP_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // accumulator, starts at one
  always_ff @(posedge clk) begin
    if (start) begin
      nbits <= delta[smx_pkg::EXP_BITS-1:0];
      zero  <= far;
      unity <= 1'b1;
      acc   <= '0;
    end else if (busy && nbits[step]) begin
      unity <= 1'b0;
      acc   <= unity ? factor : acc_next;
    end
  end

  // round to q0.16 and saturate
  assign e_rnd = {1'b0, acc} + 33'd32768;
  always_comb begin
    if (zero) begin
      e = '0;
    end else if (unity || e_rnd[smx_pkg::ACC_W]) begin
      e = '1;
    end else begin
      e = e_rnd[smx_pkg::ACC_W-1:smx_pkg::ACC_W-smx_pkg::PROB_W];
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: design/smx_div.sv
`timescale 1ns / 1ps
// restoring divider for the rounded probability, one quotient bit per cycle
// depends on smx_pkg

module smx_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [smx_pkg::PROB_W-1:0]    e,
  input  logic [smx_pkg::SUM_W-1:0]     sum,
  output logic [smx_pkg::PROB_W-1:0]    prob,
  output smx_pkg::unit_status_t         status
);

  logic                               busy;
  logic                               done;
  logic [smx_pkg::DIV_STEP_W-1:0]     step;
  logic [smx_pkg::SUM_W-1:0]          divisor;
  logic [smx_pkg::SUM_W-1:0]          rem;
  logic [smx_pkg::DIV_STEPS-1:0]      nbits;
  logic [smx_pkg::DIV_STEPS-1:0]      quo;
  logic [smx_pkg::NUM_W-1:0]          num;
  logic [smx_pkg::SUM_W:0]            trial;
  logic [smx_pkg::SUM_W:0]            diff;
  logic                               fits;

  // numerator e*2^16 + sum/2
  assign num = {1'b0, e, 16'd0} + smx_pkg::NUM_W'(sum >> 1);

  // one trial subtraction per step
  assign trial = {rem, nbits[smx_pkg::DIV_STEPS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == smx_pkg::DIV_STEP_W'(smx_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= sum;
      rem     <= smx_pkg::SUM_W'(num[smx_pkg::NUM_W-1:smx_pkg::DIV_STEPS]);
      nbits   <= num[smx_pkg::DIV_STEPS-1:0];
      quo     <= '0;
    end else if (busy) begin
      rem   <= fits ? diff[smx_pkg::SUM_W-1:0] : trial[smx_pkg::SUM_W-1:0];
      nbits <= {nbits[smx_pkg::DIV_STEPS-2:0], 1'b0};
      quo   <= {quo[smx_pkg::DIV_STEPS-2:0], fits};
    end
  end

  // saturate and guard a zero sum
  always_comb begin
    if (divisor == '0) begin
      prob = '0;
    end else if (quo[smx_pkg::DIV_STEPS-1]) begin
      prob = '1;
    end else begin
      prob = quo[smx_pkg::PROB_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: design/softmax_vector_top.sv
`timescale 1ns / 1ps
// softmax over one vector: samples load one item per cycle into the sample ram while
// in the load state. after the last item a summing pass reads each element from ram and
// runs the 12-step exponential unit, then an output pass runs the exponential again plus
// the 17-step divider for each element; the output register waits on back-pressure.
// synchronous active-high reset clears control state; no clearing pass is needed.
// depends on smx_pkg, smx_ram, smx_exp, smx_div

module softmax_vector_top #(
  parameter int MAX_LEN = smx_pkg::MAX_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [smx_pkg::SAMPLE_W-1:0]       s_tdata,  // [15:0] sample
  input  logic                               s_tlast,  // last
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [smx_pkg::TDATA_OUT_W-1:0]    m_tdata,  // [15:0] prob, [21:16] position
  output logic                               m_tlast   // end_of_row
);

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    LOAD, SUM_RD, SUM_EXP, SUM_WAIT, EMIT_RD, EMIT_EXP, EMIT_WAIT, EMIT_DIV, EMIT_OUT
  } state_t;

  state_t                             state;
  logic signed [smx_pkg::SAMPLE_W-1:0] running_max;
  logic [CNT_W-1:0]                   element_count;
  logic [smx_pkg::SUM_W-1:0]          exp_sum;
  logic [ADDR_W-1:0]                  idx;

  logic                               in_acc;
  logic                               room;
  logic signed [smx_pkg::SAMPLE_W-1:0] sample;
  logic                               ram_we;
  logic signed [smx_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [smx_pkg::SAMPLE_W:0]  dist_full;
  logic [smx_pkg::SAMPLE_W-1:0]       delta;
  logic                               exp_start;
  logic [smx_pkg::PROB_W-1:0]         e_val;
  smx_pkg::unit_status_t              exp_stat;
  logic                               div_start;
  logic [smx_pkg::PROB_W-1:0]         prob;
  smx_pkg::unit_status_t              div_stat;
  logic [smx_pkg::SUM_W:0]            sum_add;
  logic                               at_end;
  logic                               out_free;

  // input handshake and store write
  assign s_tready = (state == LOAD);
  assign in_acc   = s_tvalid && s_tready;
  assign sample   = s_tdata;
  assign room     = (element_count < CNT_W'(MAX_LEN));
  assign ram_we   = in_acc && room;

  smx_ram #(
    .WIDTH (smx_pkg::SAMPLE_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (element_count[ADDR_W-1:0]),
    .wdata (sample),
    .raddr (idx),
    .rdata (rd_data)
  );

  // distance below the maximum, never negative
  assign dist_full = {running_max[smx_pkg::SAMPLE_W-1], running_max}
                   - {rd_data[smx_pkg::SAMPLE_W-1], rd_data};
  assign delta     = dist_full[smx_pkg::SAMPLE_W-1:0];
  assign exp_start = (state == SUM_EXP) || (state == EMIT_EXP);

  smx_exp u_exp (
    .clk    (clk),
    .rst    (rst),
    .start  (exp_start),
    .delta  (delta),
    .e      (e_val),
    .status (exp_stat)
  );

  assign div_start = (state == EMIT_WAIT) && exp_stat.done;

  smx_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .e      (e_val),
    .sum    (exp_sum),
    .prob   (prob),
    .status (div_stat)
  );

  // saturating sum and pass bookkeeping
  assign sum_add  = {1'b0, exp_sum} + (smx_pkg::SUM_W + 1)'(e_val);
  assign at_end   = ((CNT_W'(idx) + CNT_W'(1)) == element_count);
  assign out_free = !m_tvalid || m_tready;

  // sequencer, vector state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= LOAD;
      running_max   <= {1'b1, {(smx_pkg::SAMPLE_W-1){1'b0}}};
      element_count <= '0;
      exp_sum       <= '0;
      idx           <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !(state == EMIT_OUT && out_free)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        LOAD: begin
          if (in_acc) begin
            if (room) begin
              element_count <= element_count + 1'b1;
              if (sample > running_max) begin
                running_max <= sample;
              end
            end
            if (s_tlast) begin
              idx     <= '0;
              exp_sum <= '0;
              state   <= SUM_RD;
            end
          end
        end
        SUM_RD:  state <= SUM_EXP;
        SUM_EXP: state <= SUM_WAIT;
        SUM_WAIT: begin
          if (exp_stat.done) begin
            exp_sum <= sum_add[smx_pkg::SUM_W] ? '1 : sum_add[smx_pkg::SUM_W-1:0];
            if (at_end) begin
              idx   <= '0;
              state <= EMIT_RD;
            end else begin
              idx   <= idx + 1'b1;
              state <= SUM_RD;
            end
          end
        end
        EMIT_RD:  state <= EMIT_EXP;
        EMIT_EXP: state <= EMIT_WAIT;
        EMIT_WAIT: begin
          if (exp_stat.done) begin
            state <= EMIT_DIV;
          end
        end
        EMIT_DIV: begin
          if (div_stat.done) begin
            state <= EMIT_OUT;
          end
        end
        EMIT_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (at_end) begin
              running_max   <= {1'b1, {(smx_pkg::SAMPLE_W-1){1'b0}}};
              element_count <= '0;
              exp_sum       <= '0;
              idx           <= '0;
              state         <= LOAD;
            end else begin
              idx   <= idx + 1'b1;
              state <= EMIT_RD;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == EMIT_OUT && out_free) begin
      m_tdata <= {{(smx_pkg::TDATA_OUT_W - smx_pkg::PROB_W - smx_pkg::POS_W){1'b0}},
                  smx_pkg::POS_W'(idx), prob};
      m_tlast <= at_end;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_W'(MAX_LEN))
    else $error("element count beyond capacity");

  a_exp_idle_on_load: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !exp_stat.busy && !div_stat.busy)
    else $error("arithmetic busy while loading");

  a_exp_done_expected: assert property (@(posedge clk) disable iff (rst)
    exp_stat.done |-> (state == SUM_WAIT) || (state == EMIT_WAIT))
    else $error("exponential result with nobody waiting");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == EMIT_DIV))
    else $error("quotient with nobody waiting");

  a_sum_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT_RD) |-> (exp_sum != '0))
    else $error("zero sum entering output pass");

endmodule
